@@ rtl/mrdo_pkg.sv @@
// mrdo_pkg: shared types, codes and sizes of the message ring
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package mrdo_pkg;

   localparam int RING_BYTES = 4096;
   localparam int HDR_BYTES  = 8;
   localparam int ADDR_W     = $clog2(RING_BYTES);
   localparam int MAX_LEN    = RING_BYTES - HDR_BYTES;

   localparam logic [1:0] FN_BEGIN = 2'd0;
   localparam logic [1:0] FN_BYTE  = 2'd1;
   localparam logic [1:0] FN_PEEK  = 2'd2;
   localparam logic [1:0] FN_READ  = 2'd3;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_TOO_LARGE = 3'd1;
   localparam logic [2:0] ST_CORRUPT   = 3'd2;
   localparam logic [2:0] ST_NONE      = 3'd3;
   localparam logic [2:0] ST_SEQ       = 3'd4;

   typedef struct packed {
      logic [1:0]  func;
      logic [12:0] body_len;
      logic [7:0]  data_byte;
      logic [63:0] now_time;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [9:0]  dropped_count;
      logic [11:0] message_length;
      logic [7:0]  data_out;
      logic        last_of_message;
      logic [9:0]  message_count;
      logic [63:0] read_position;
      logic [63:0] write_position;
      logic [63:0] last_insert_time;
      logic [63:0] last_consume_time;
   } rsp_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_DROP,
      OP_HDR_STEP,
      OP_WALK_ADV,
      OP_HDR_WR,
      OP_BYTE_WR,
      OP_PEEK,
      OP_CONSUME,
      OP_DATA_RD,
      OP_DATA_GET,
      OP_RESP
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [2:0] status;
   } cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic       too_large;
      logic       need_drop;
      logic       active;
      logic       drop_done;
      logic       left_lt_hdr;
      logic       hdr_bad;
      logic       left_lt_msg;
      logic       read_done;
      logic       hdr_last;
      logic       wr_last;
      logic       out_free;
   } stat_type;

endpackage
`default_nettype wire

@@ rtl/mrdo_ram.sv @@
// mrdo_ram: generic single write, single read ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module mrdo_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ rtl/mrdo_ctrl.sv @@
// mrdo_ctrl: sequencer for insert, drop walk, peek and read
// depends on mrdo_pkg
`timescale 1ns / 1ps
`default_nettype none
module mrdo_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire mrdo_pkg::stat_type stat,
   output mrdo_pkg::cmd_type      cmd
);

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_DECODE = 9'b000000010,
      S_WALK   = 9'b000000100,
      S_HREAD  = 9'b000001000,
      S_HEVAL  = 9'b000010000,
      S_HWRITE = 9'b000100000,
      S_DWAIT  = 9'b001000000,
      S_RESP   = 9'b010000000,
      S_SPARE  = 9'b100000000
   } state_type;

   state_type  state_ff, state_in;
   logic [2:0] st_ff, st_in;

   always_comb begin
      state_in   = state_ff;
      st_in      = st_ff;
      cmd.op     = mrdo_pkg::OP_NONE;
      cmd.status = st_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = mrdo_pkg::OP_LOAD;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            st_in    = mrdo_pkg::ST_OK;
            state_in = S_RESP;
            if (stat.func == mrdo_pkg::FN_BEGIN) begin
               if (stat.too_large) begin
                  st_in = mrdo_pkg::ST_TOO_LARGE;
               end else if (stat.need_drop) begin
                  state_in = S_WALK;
               end else begin
                  state_in = S_HWRITE;
               end
            end else if (stat.func == mrdo_pkg::FN_BYTE) begin
               if (stat.active) begin
                  cmd.op = mrdo_pkg::OP_BYTE_WR;
               end else begin
                  st_in = mrdo_pkg::ST_SEQ;
               end
            end else if (stat.left_lt_hdr) begin
               st_in = mrdo_pkg::ST_NONE;
            end else begin
               state_in = S_HREAD;
            end
         end
         S_WALK: begin
            if (stat.drop_done) begin
               cmd.op   = mrdo_pkg::OP_DROP;
               state_in = S_HWRITE;
            end else if (stat.left_lt_hdr) begin
               st_in    = mrdo_pkg::ST_CORRUPT;
               state_in = S_RESP;
            end else begin
               state_in = S_HREAD;
            end
         end
         S_HREAD: begin
            cmd.op = mrdo_pkg::OP_HDR_STEP;
            if (stat.hdr_last) begin
               state_in = S_HEVAL;
            end
         end
         S_HEVAL: begin
            state_in = S_RESP;
            if (stat.hdr_bad) begin
               st_in = mrdo_pkg::ST_CORRUPT;
            end else if (stat.func == mrdo_pkg::FN_BEGIN) begin
               if (stat.left_lt_msg) begin
                  st_in = mrdo_pkg::ST_CORRUPT;
               end else begin
                  cmd.op   = mrdo_pkg::OP_WALK_ADV;
                  state_in = S_WALK;
               end
            end else if (stat.left_lt_msg) begin
               st_in = mrdo_pkg::ST_NONE;
            end else if (stat.func == mrdo_pkg::FN_PEEK) begin
               cmd.op = mrdo_pkg::OP_PEEK;
            end else if (stat.read_done) begin
               cmd.op = mrdo_pkg::OP_CONSUME;
            end else begin
               cmd.op   = mrdo_pkg::OP_DATA_RD;
               state_in = S_DWAIT;
            end
         end
         S_DWAIT: begin
            cmd.op   = mrdo_pkg::OP_DATA_GET;
            state_in = S_RESP;
         end
         S_HWRITE: begin
            cmd.op = mrdo_pkg::OP_HDR_WR;
            st_in  = mrdo_pkg::ST_OK;
            if (stat.wr_last) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (stat.out_free) begin
               cmd.op   = mrdo_pkg::OP_RESP;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         st_ff    <= mrdo_pkg::ST_OK;
      end else begin
         state_ff <= state_in;
         st_ff    <= st_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule
`default_nettype wire

@@ rtl/mrdo_datapath.sv @@
// mrdo_datapath: pointers, counters, header capture, ring ram and result register
// depends on mrdo_pkg and mrdo_ram
`timescale 1ns / 1ps
`default_nettype none
module mrdo_datapath (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire mrdo_pkg::req_type  req_data,
   input  wire mrdo_pkg::cmd_type  cmd,
   output mrdo_pkg::stat_type      stat,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output mrdo_pkg::rsp_type       rsp_data
);

   localparam int AW = mrdo_pkg::ADDR_W;

   mrdo_pkg::req_type req_ff;
   mrdo_pkg::rsp_type rsp_ff;
   logic [63:0] wp_ff, rp_ff, dp_ff, pw_ff, itime_ff, ctime_ff;
   logic [9:0]  count_ff, n_ff, dropped_ff;
   logic        active_ff, hinz_ff, last_ff, rsp_valid_ff;
   logic [12:0] rem_ff, off_ff;
   logic [3:0]  cnt_ff;
   logic [15:0] hlen_ff;
   logic [11:0] mlen_ff;
   logic [7:0]  dout_ff;

   logic [13:0]   total;
   logic [63:0]   used, freeb, left, freeb_dp, msg_total;
   logic [11:0]   l12;
   logic          byte_last;
   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [7:0]    wr_data, rd_data;
   logic [2:0]    bidx;

   assign total     = 14'(req_ff.body_len) + 14'(mrdo_pkg::HDR_BYTES);
   assign used      = wp_ff - rp_ff;
   assign freeb     = 64'(mrdo_pkg::RING_BYTES) - used;
   assign left      = wp_ff - dp_ff;
   assign freeb_dp  = 64'(mrdo_pkg::RING_BYTES) - left;
   assign l12       = hlen_ff[11:0];
   assign msg_total = 64'(l12) + 64'(mrdo_pkg::HDR_BYTES);
   assign byte_last = (off_ff + 13'd1) == 13'(l12);
   assign bidx      = cnt_ff[2:0] - 3'd1;

   always_comb begin
      stat.func        = req_ff.func;
      stat.too_large   = req_ff.body_len > 13'(mrdo_pkg::MAX_LEN);
      stat.need_drop   = freeb < 64'(total);
      stat.active      = active_ff;
      stat.drop_done   = (n_ff != 10'd0) && (freeb_dp >= 64'(total));
      stat.left_lt_hdr = left < 64'(mrdo_pkg::HDR_BYTES);
      stat.hdr_bad     = hinz_ff || (hlen_ff > 16'(mrdo_pkg::MAX_LEN));
      stat.left_lt_msg = left < msg_total;
      stat.read_done   = (l12 == 12'd0) || (off_ff >= 13'(l12));
      stat.hdr_last    = cnt_ff == 4'd8;
      stat.wr_last     = cnt_ff == 4'd7;
      stat.out_free    = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = pw_ff[AW-1:0];
      wr_data = req_ff.data_byte;
      rd_addr = dp_ff[AW-1:0] + AW'(cnt_ff[2:0]);
      case (cmd.op)
         mrdo_pkg::OP_HDR_WR: begin
            wr_en   = 1'b1;
            wr_addr = wp_ff[AW-1:0] + AW'(cnt_ff[2:0]);
            case (cnt_ff[2:0])
               3'd0:    wr_data = req_ff.body_len[7:0];
               3'd1:    wr_data = {3'b000, req_ff.body_len[12:8]};
               default: wr_data = 8'd0;
            endcase
         end
         mrdo_pkg::OP_BYTE_WR: begin
            wr_en = 1'b1;
         end
         mrdo_pkg::OP_DATA_RD: begin
            rd_addr = rp_ff[AW-1:0] + AW'(mrdo_pkg::HDR_BYTES) + off_ff[AW-1:0];
         end
         default: begin
         end
      endcase
   end

   mrdo_ram #(.WIDTH(8), .DEPTH(mrdo_pkg::RING_BYTES)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= '0;
         rp_ff        <= '0;
         pw_ff        <= '0;
         itime_ff     <= '0;
         ctime_ff     <= '0;
         count_ff     <= '0;
         active_ff    <= 1'b0;
         rem_ff       <= '0;
         off_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.op == mrdo_pkg::OP_RESP) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (cmd.op)
            mrdo_pkg::OP_LOAD: begin
               req_ff     <= req_data;
               dp_ff      <= rp_ff;
               n_ff       <= '0;
               cnt_ff     <= '0;
               dropped_ff <= '0;
               mlen_ff    <= '0;
               dout_ff    <= '0;
               last_ff    <= 1'b0;
               if (req_data.func == mrdo_pkg::FN_BEGIN) begin
                  active_ff <= 1'b0;
                  rem_ff    <= '0;
               end
            end
            mrdo_pkg::OP_DROP: begin
               rp_ff      <= dp_ff;
               count_ff   <= count_ff - n_ff;
               off_ff     <= '0;
               dropped_ff <= n_ff;
            end
            mrdo_pkg::OP_HDR_STEP: begin
               if (cnt_ff == 4'd0) begin
                  hinz_ff <= 1'b0;
               end else if (bidx == 3'd0) begin
                  hlen_ff[7:0] <= rd_data;
               end else if (bidx == 3'd1) begin
                  hlen_ff[15:8] <= rd_data;
               end else begin
                  hinz_ff <= hinz_ff || (rd_data != 8'd0);
               end
               cnt_ff <= (cnt_ff == 4'd8) ? 4'd0 : cnt_ff + 4'd1;
            end
            mrdo_pkg::OP_WALK_ADV: begin
               dp_ff <= dp_ff + msg_total;
               n_ff  <= n_ff + 10'd1;
            end
            mrdo_pkg::OP_HDR_WR: begin
               if (cnt_ff == 4'd7) begin
                  cnt_ff <= '0;
                  pw_ff  <= wp_ff + 64'(mrdo_pkg::HDR_BYTES);
                  rem_ff <= req_ff.body_len;
                  if (req_ff.body_len == 13'd0) begin
                     wp_ff     <= wp_ff + 64'(mrdo_pkg::HDR_BYTES);
                     count_ff  <= count_ff + 10'd1;
                     itime_ff  <= req_ff.now_time;
                     active_ff <= 1'b0;
                  end else begin
                     active_ff <= 1'b1;
                  end
               end else begin
                  cnt_ff <= cnt_ff + 4'd1;
               end
            end
            mrdo_pkg::OP_BYTE_WR: begin
               pw_ff  <= pw_ff + 64'd1;
               rem_ff <= rem_ff - 13'd1;
               if (rem_ff == 13'd1) begin
                  wp_ff     <= pw_ff + 64'd1;
                  count_ff  <= count_ff + 10'd1;
                  itime_ff  <= req_ff.now_time;
                  active_ff <= 1'b0;
               end
            end
            mrdo_pkg::OP_PEEK: begin
               mlen_ff <= l12;
            end
            mrdo_pkg::OP_CONSUME: begin
               last_ff  <= 1'b1;
               rp_ff    <= rp_ff + msg_total;
               count_ff <= count_ff - 10'd1;
               ctime_ff <= req_ff.now_time;
               off_ff   <= '0;
            end
            mrdo_pkg::OP_DATA_GET: begin
               dout_ff <= rd_data;
               if (byte_last) begin
                  last_ff  <= 1'b1;
                  rp_ff    <= rp_ff + msg_total;
                  count_ff <= count_ff - 10'd1;
                  ctime_ff <= req_ff.now_time;
                  off_ff   <= '0;
               end else begin
                  off_ff <= off_ff + 13'd1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == mrdo_pkg::OP_RESP) begin
         rsp_ff.status            <= cmd.status;
         rsp_ff.dropped_count     <= dropped_ff;
         rsp_ff.message_length    <= mlen_ff;
         rsp_ff.data_out          <= dout_ff;
         rsp_ff.last_of_message   <= last_ff;
         rsp_ff.message_count     <= count_ff;
         rsp_ff.read_position     <= rp_ff;
         rsp_ff.write_position    <= wp_ff;
         rsp_ff.last_insert_time  <= itime_ff;
         rsp_ff.last_consume_time <= ctime_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used <= 64'(mrdo_pkg::RING_BYTES))
      else $error("ring occupancy exceeds ring size");

   a_active_rem: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (rem_ff != 13'd0))
      else $error("open insert with nothing remaining");

   a_resp_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == mrdo_pkg::OP_RESP) |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result overwritten before taken");

endmodule
`default_nettype wire

@@ rtl/message_ring_drop_oldest.sv @@
// message ring: stalls requests while one transaction is in flight
// states to result valid: stray byte, too large, short ring, payload byte: decode, resp
// peek: decode, hread, heval, resp; read adds dwait, or not when it only consumes a
// finished message; begin insert: decode, hwrite, resp, after a drop walk (walk, hread,
// heval per dropped message) when needed; next accepted in the cycle the result turns valid
// reset (synchronous): pointers, counters, times clear; ring contents undefined
`timescale 1ns / 1ps
`default_nettype none
module message_ring_drop_oldest (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire mrdo_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output mrdo_pkg::rsp_type      rsp_data
);

   mrdo_pkg::cmd_type  cmd;
   mrdo_pkg::stat_type stat;

   mrdo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   mrdo_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

@@ tb/sv/tb_message_ring_drop_oldest.sv @@
// tb_message_ring_drop_oldest: self-checking bench for the message ring with oldest-drop
// predicts every response with a behavioral copy of the ring; depends on mrdo_pkg and the rtl
`timescale 1ns / 1ps
module tb_message_ring_drop_oldest;

   localparam int CYCLE_LIMIT = 1000000;

   class ring_scoreboard;
      bit [7:0]        ring [mrdo_pkg::RING_BYTES];
      longint unsigned wr_ptr, rd_ptr, pend_ptr, insert_time, consume_time;
      bit [9:0]        held_msgs;
      bit              open_insert;
      int              remain, rd_off, errors;
      mrdo_pkg::rsp_type expected_q [$];

      function longint unsigned header_at(longint unsigned p);
         longint unsigned v;
         v = 0;
         for (int i = mrdo_pkg::HDR_BYTES - 1; i >= 0; i--)
            v = (v << 8) | ring[(p + i) % mrdo_pkg::RING_BYTES];
         return v;
      endfunction

      function void commit(longint unsigned now);
         wr_ptr = pend_ptr;
         held_msgs++;
         insert_time = now;
         open_insert = 0;
         remain = 0;
      endfunction

      function logic [2:0] oldest(output longint unsigned len);
         longint unsigned avail, l;
         len = 0;
         avail = wr_ptr - rd_ptr;
         if (avail < mrdo_pkg::HDR_BYTES) return mrdo_pkg::ST_NONE;
         l = header_at(rd_ptr);
         if (l > mrdo_pkg::MAX_LEN) return mrdo_pkg::ST_CORRUPT;
         if (avail < mrdo_pkg::HDR_BYTES + l) return mrdo_pkg::ST_NONE;
         len = l;
         return mrdo_pkg::ST_OK;
      endfunction

      function mrdo_pkg::rsp_type predict(mrdo_pkg::req_type r);
         mrdo_pkg::rsp_type o;
         longint unsigned total, freeb, dp, n, l, left, len;
         bit ok;
         logic [2:0] s;
         o = '0;
         o.status = mrdo_pkg::ST_OK;
         case (r.func)
            mrdo_pkg::FN_BEGIN: begin
               total = mrdo_pkg::HDR_BYTES + r.body_len;
               open_insert = 0;
               remain = 0;
               if (total > mrdo_pkg::RING_BYTES) o.status = mrdo_pkg::ST_TOO_LARGE;
               else begin
                  freeb = mrdo_pkg::RING_BYTES - (wr_ptr - rd_ptr);
                  ok = 1;
                  if (freeb < total) begin
                     dp = rd_ptr;
                     n = 0;
                     while (1) begin
                        left = wr_ptr - dp;
                        if (left < mrdo_pkg::HDR_BYTES) begin
                           ok = 0;
                           break;
                        end
                        l = header_at(dp);
                        if (l > mrdo_pkg::MAX_LEN || left < mrdo_pkg::HDR_BYTES + l) begin
                           ok = 0;
                           break;
                        end
                        dp += mrdo_pkg::HDR_BYTES + l;
                        n++;
                        freeb = mrdo_pkg::RING_BYTES - (wr_ptr - dp);
                        if (freeb >= total) break;
                     end
                     if (ok) begin
                        rd_ptr = dp;
                        held_msgs -= n[9:0];
                        rd_off = 0;
                        o.dropped_count = n[9:0];
                     end
                  end
                  if (!ok) o.status = mrdo_pkg::ST_CORRUPT;
                  else begin
                     for (int i = 0; i < mrdo_pkg::HDR_BYTES; i++)
                        ring[(wr_ptr + i) % mrdo_pkg::RING_BYTES] =
                           8'(64'(r.body_len) >> (8 * i));
                     pend_ptr = wr_ptr + mrdo_pkg::HDR_BYTES;
                     remain = r.body_len;
                     open_insert = 1;
                     if (r.body_len == 0) commit(r.now_time);
                  end
               end
            end
            mrdo_pkg::FN_BYTE: begin
               if (!open_insert) o.status = mrdo_pkg::ST_SEQ;
               else begin
                  ring[pend_ptr % mrdo_pkg::RING_BYTES] = r.data_byte;
                  pend_ptr++;
                  remain--;
                  if (remain == 0) commit(r.now_time);
               end
            end
            default: begin
               s = oldest(len);
               if (s != mrdo_pkg::ST_OK) o.status = s;
               else if (r.func == mrdo_pkg::FN_PEEK) o.message_length = len[11:0];
               else if (len == 0 || rd_off >= len) o.last_of_message = 1;
               else begin
                  o.data_out =
                     ring[(rd_ptr + mrdo_pkg::HDR_BYTES + rd_off) % mrdo_pkg::RING_BYTES];
                  rd_off++;
                  if (rd_off == len) o.last_of_message = 1;
               end
               if (s == mrdo_pkg::ST_OK && r.func == mrdo_pkg::FN_READ &&
                   o.last_of_message) begin
                  rd_ptr += mrdo_pkg::HDR_BYTES + len;
                  held_msgs--;
                  consume_time = r.now_time;
                  rd_off = 0;
               end
            end
         endcase
         o.message_count     = held_msgs;
         o.read_position     = rd_ptr;
         o.write_position    = wr_ptr;
         o.last_insert_time  = insert_time;
         o.last_consume_time = consume_time;
         return o;
      endfunction

      function void note_request(mrdo_pkg::req_type r);
         expected_q.push_back(predict(r));
      endfunction

      function void field(string name, logic [63:0] e, logic [63:0] a);
         if (e !== a) begin
            errors++;
            $display("%0t mismatch %s: expected %0h actual %0h", $time, name, e, a);
         end
      endfunction

      function void check_response(mrdo_pkg::rsp_type a);
         mrdo_pkg::rsp_type e;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t unexpected response: expected none actual %0h", $time, a);
            return;
         end
         e = expected_q.pop_front();
         field("status", e.status, a.status);
         field("dropped_count", e.dropped_count, a.dropped_count);
         field("message_length", e.message_length, a.message_length);
         field("data_out", e.data_out, a.data_out);
         field("last_of_message", e.last_of_message, a.last_of_message);
         field("message_count", e.message_count, a.message_count);
         field("read_position", e.read_position, a.read_position);
         field("write_position", e.write_position, a.write_position);
         field("last_insert_time", e.last_insert_time, a.last_insert_time);
         field("last_consume_time", e.last_consume_time, a.last_consume_time);
      endfunction
   endclass

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_stall;
   mrdo_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 0;
   mrdo_pkg::rsp_type rsp_data;

   ring_scoreboard sb = new();
   int  sent = 0;
   int  cycles = 0;
   bit  no_idle = 0;
   bit  hold_go = 0;

   message_ring_drop_oldest i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // response checked before the new transaction is predicted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) sb.check_response(rsp_data);
         if (req_valid && !req_stall) sb.note_request(req_data);
      end
   end

   function int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // receiver side: random stalls plus one long hold-off
   initial begin
      int run;
      bit held;
      run = 0;
      held = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_go && !held) begin
            held = 1;
            rsp_stall <= 1;
            repeat (400) @(posedge clock);
         end else if (run > 0) begin
            run--;
            rsp_stall <= 1;
         end else begin
            run = pick_gap();
            rsp_stall <= (run > 0);
            if (run > 0) run--;
         end
      end
   end

   task automatic send(input logic [1:0] fn, input int len, input logic [7:0] b,
                       input logic [63:0] now);
      int g;
      g = pick_gap();
      if (g > 0) begin
         req_valid <= 0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1;
      req_data  <= '{func: fn, body_len: 13'(len), data_byte: b, now_time: now};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
   endtask

   function logic [63:0] stamp();
      return {$urandom, $urandom};
   endfunction

   task automatic message(input int len, input int cut);
      send(mrdo_pkg::FN_BEGIN, len, $urandom, stamp());
      for (int i = 0; i < len - cut; i++) send(mrdo_pkg::FN_BYTE, 0, $urandom, stamp());
   endtask

   initial begin
      int r, len;
      repeat (12) @(posedge clock);
      reset <= 0;

      // directed: empty ring, sequencing errors, extremes
      send(mrdo_pkg::FN_PEEK, 0, 8'h00, 64'd0);
      send(mrdo_pkg::FN_READ, 8191, 8'hFF, '1);
      send(mrdo_pkg::FN_BYTE, 0, 8'hFF, 64'd5);
      send(mrdo_pkg::FN_BEGIN, 8191, 8'h00, 64'd6);
      send(mrdo_pkg::FN_BEGIN, mrdo_pkg::MAX_LEN + 1, 8'h00, 64'd7);
      send(mrdo_pkg::FN_BEGIN, 0, 8'hFF, '1);
      send(mrdo_pkg::FN_BEGIN, 3, 8'h00, 64'd9);
      send(mrdo_pkg::FN_BYTE, 0, 8'h00, 64'd10);
      send(mrdo_pkg::FN_BYTE, 0, 8'hFF, 64'd11);
      send(mrdo_pkg::FN_BYTE, 0, 8'hA5, '1);
      send(mrdo_pkg::FN_BEGIN, 2, 8'h00, 64'd13);
      send(mrdo_pkg::FN_BYTE, 0, 8'h5A, 64'd14);
      send(mrdo_pkg::FN_BEGIN, 1, 8'h00, 64'd15);
      send(mrdo_pkg::FN_BYTE, 0, 8'h3C, 64'd16);
      send(mrdo_pkg::FN_PEEK, 0, 8'h00, 64'd17);
      send(mrdo_pkg::FN_READ, 0, 8'h00, '1);
      send(mrdo_pkg::FN_PEEK, 0, 8'h00, 64'd19);
      repeat (3) send(mrdo_pkg::FN_READ, 0, 8'h00, stamp());
      send(mrdo_pkg::FN_READ, 0, 8'h00, 64'd0);
      send(mrdo_pkg::FN_READ, 0, 8'h00, 64'd21);
      send(mrdo_pkg::FN_PEEK, 0, 8'h00, 64'd22);

      // random: fill with short messages so drops happen, then a mixed load
      while (sent < 1050) begin
         r = $urandom_range(0, 99);
         no_idle = (sent > 700 && sent < 800);
         if (sent > 250) hold_go = 1;
         if (sent < 560) begin
            if (r < 85) send(mrdo_pkg::FN_BEGIN, 0, $urandom, stamp());
            else if (r < 95) message($urandom_range(1, 6), 0);
            else send($urandom_range(0, 1) ? mrdo_pkg::FN_PEEK : mrdo_pkg::FN_READ,
                      $urandom, $urandom, stamp());
         end else if (r < 35) begin
            len = $urandom_range(0, 99);
            if (len < 70) len = $urandom_range(0, 8);
            else if (len < 98) len = $urandom_range(9, 64);
            else len = $urandom_range(100, 300);
            message(len, 0);
         end else if (r < 45) send(mrdo_pkg::FN_PEEK, $urandom, $urandom, stamp());
         else if (r < 75) send(mrdo_pkg::FN_READ, $urandom, $urandom, stamp());
         else if (r < 80) send(mrdo_pkg::FN_BYTE, $urandom, $urandom, stamp());
         else if (r < 85) send(mrdo_pkg::FN_BEGIN,
                               $urandom_range(mrdo_pkg::MAX_LEN + 1, 8191), $urandom, stamp());
         else if (r < 90) begin
            len = $urandom_range(2, 20);
            message(len, $urandom_range(1, len));
         end else begin
            repeat ($urandom_range(1, 10))
               send(mrdo_pkg::FN_READ, $urandom, $urandom, stamp());
         end
      end

      req_valid <= 0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule

@@ filelist.f @@
rtl/mrdo_pkg.sv
rtl/mrdo_ram.sv
rtl/mrdo_ctrl.sv
rtl/mrdo_datapath.sv
rtl/message_ring_drop_oldest.sv
tb/sv/tb_message_ring_drop_oldest.sv
